/* hdl/dpc_pkg.sv */
// Package: widths, word types, state and status codes for the path counter.
`timescale 1ns / 1ps
package dpc_pkg;
  localparam int MAX_NODES  = 1024;
  localparam int MAX_EDGES  = 4096;
  localparam int COUNT_BITS = 64;
  localparam int NODE_W     = $clog2(MAX_NODES);
  localparam int EIDX_W     = $clog2(MAX_EDGES);
  localparam int LINK_W     = $clog2(MAX_EDGES + 1);
  localparam int CFG_IDX_W  = 2;
  localparam logic [LINK_W-1:0] NO_EDGE = LINK_W'(MAX_EDGES);

  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 2'd1;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_SOURCE = 3'd1;
  localparam logic [2:0] ST_NO_TARGET = 3'd2;
  localparam logic [2:0] ST_CYCLE     = 3'd3;
  localparam logic [2:0] ST_OVERFLOW  = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;

  typedef struct packed {
    logic [9:0] from_node;
    logic [9:0] to_node;
    logic       has_edge;
    logic       last_item;
  } in_t;

  typedef struct packed {
    logic [63:0] path_count;
    logic [2:0]  status;
  } out_t;

  typedef struct packed {
    logic              seen;
    logic              mval;
    logic              visit;
    logic [LINK_W-1:0] head;
    logic [EIDX_W-1:0] tail;
  } node_t;

  typedef struct packed {
    logic [NODE_W-1:0]     node;
    logic [LINK_W-1:0]     cursor;
    logic [COUNT_BITS-1:0] sum;
  } stack_t;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_RD_FROM, S_UPD_FROM, S_LINK, S_RD_TO, S_UPD_TO,
    S_CK_RS, S_CK_RT, S_CK_EV, S_W_EDGE, S_W_DEST, S_W_NODE, S_W_POP,
    S_W_POP2, S_RES
  } state_t;
endpackage

/* hdl/dpc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module dpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* hdl/dpc_add.sv */
// Shared count adder with overflow detect.
`timescale 1ns / 1ps
module dpc_add (
  input  logic [dpc_pkg::COUNT_BITS-1:0] a,
  input  logic [dpc_pkg::COUNT_BITS-1:0] b,
  output logic [dpc_pkg::COUNT_BITS-1:0] sum,
  output logic                           ovf
);
  import dpc_pkg::*;
  assign {ovf, sum} = {1'b0, a} + {1'b0, b};
endmodule

/* hdl/dag_path_counter.sv */
// Path counter top level: graph loader, walk sequencer and stores.
// Items are taken one at a time: a node declaration reads and updates its
// from node; an edge links into the list it extends, then reads and updates
// its to node; a last item adds source, target and walk checks and posts the
// result. The walk reads each edge, its destination and, but for the target,
// that node, and pops finished nodes into their parents, all sums going
// through one shared 64-bit adder. After reset and each result a clearing
// pass sweeps all MAX_NODES (1024) node entries; no item is taken meanwhile.
`timescale 1ns / 1ps
module dag_path_counter (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  dpc_pkg::in_t                   item,
  output logic                           result_valid,
  input  logic                           result_ready,
  output dpc_pkg::out_t                  result,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [9:0]                     cfg_data
);
  import dpc_pkg::*;

  state_t state, state_next;
  in_t cur;
  logic [NODE_W-1:0] src_node, tgt_node, cur_n, cur_d, depth, clr_cnt;
  logic [LINK_W-1:0] edges_stored, cur_c;
  logic [EIDX_W-1:0] link_addr;
  logic full_flag;
  logic [COUNT_BITS-1:0] cur_s, res_count;
  logic [2:0] res_status;
  node_t src_w;

  logic node_we, memo_we, ed_we, el_we, st_we;
  logic [NODE_W-1:0] node_waddr, node_raddr, st_raddr;
  node_t node_wdata, nd;
  logic [$bits(node_t)-1:0] node_rdata;
  logic [COUNT_BITS-1:0] memo_rdata, add_a, add_b, add_sum;
  logic add_ovf;
  logic [EIDX_W-1:0] el_waddr;
  logic [LINK_W-1:0] el_wdata, el_rdata;
  logic [NODE_W-1:0] ed_rdata;
  logic [$bits(stack_t)-1:0] st_rdata;
  stack_t sw;
  logic e_full, walk_go, push_full;

  assign nd         = node_t'(node_rdata);
  assign sw         = stack_t'(st_rdata);
  assign e_full     = (edges_stored == NO_EDGE);
  assign item_ready = (state == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign walk_go    = !full_flag && src_w.seen && nd.seen && (src_node != tgt_node);
  assign push_full  = (depth == NODE_W'(MAX_NODES - 1));

  dpc_ram #(.WIDTH($bits(node_t)), .DEPTH(MAX_NODES)) u_node (
    .clk, .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
    .raddr(node_raddr), .rdata(node_rdata));
  dpc_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_NODES)) u_memo (
    .clk, .we(memo_we), .waddr(cur_n), .wdata(cur_s),
    .raddr(node_raddr), .rdata(memo_rdata));
  dpc_ram #(.WIDTH(NODE_W), .DEPTH(MAX_EDGES)) u_edest (
    .clk, .we(ed_we), .waddr(edges_stored[EIDX_W-1:0]), .wdata(cur.to_node),
    .raddr(cur_c[EIDX_W-1:0]), .rdata(ed_rdata));
  dpc_ram #(.WIDTH(LINK_W), .DEPTH(MAX_EDGES)) u_elink (
    .clk, .we(el_we), .waddr(el_waddr), .wdata(el_wdata),
    .raddr(cur_c[EIDX_W-1:0]), .rdata(el_rdata));
  dpc_ram #(.WIDTH($bits(stack_t)), .DEPTH(MAX_NODES)) u_stack (
    .clk, .we(st_we), .waddr(depth), .wdata({cur_n, cur_c, cur_s}),
    .raddr(st_raddr), .rdata(st_rdata));

  dpc_add u_add (.a(add_a), .b(add_b), .sum(add_sum), .ovf(add_ovf));

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLR:      if (clr_cnt == NODE_W'(MAX_NODES - 1)) state_next = S_IDLE;
      S_IDLE:     if (item_valid) state_next = S_RD_FROM;
      S_RD_FROM:  state_next = S_UPD_FROM;
      S_UPD_FROM: begin
        if (!cur.has_edge) state_next = cur.last_item ? S_CK_RS : S_IDLE;
        else if (!e_full && nd.head != NO_EDGE) state_next = S_LINK;
        else state_next = S_RD_TO;
      end
      S_LINK:     state_next = S_RD_TO;
      S_RD_TO:    state_next = S_UPD_TO;
      S_UPD_TO:   state_next = cur.last_item ? S_CK_RS : S_IDLE;
      S_CK_RS:    state_next = S_CK_RT;
      S_CK_RT:    state_next = S_CK_EV;
      S_CK_EV:    state_next = walk_go ? S_W_EDGE : S_RES;
      S_W_EDGE:   state_next = (cur_c == NO_EDGE) ? S_W_POP : S_W_DEST;
      S_W_DEST: begin
        if (ed_rdata == tgt_node) state_next = add_ovf ? S_RES : S_W_EDGE;
        else state_next = S_W_NODE;
      end
      S_W_NODE: begin
        if (nd.mval) state_next = add_ovf ? S_RES : S_W_EDGE;
        else if (nd.visit || push_full) state_next = S_RES;
        else state_next = S_W_EDGE;
      end
      S_W_POP:    state_next = (depth == '0) ? S_RES : S_W_POP2;
      S_W_POP2:   state_next = add_ovf ? S_RES : S_W_EDGE;
      S_RES:      if (!result_valid || result_ready) state_next = S_CLR;
      default:    state_next = S_CLR;
    endcase
  end

  always_comb begin
    node_we = 1'b0; node_waddr = cur.from_node; node_wdata = nd; node_raddr = '0;
    memo_we = 1'b0; ed_we = 1'b0; el_we = 1'b0;
    el_waddr = edges_stored[EIDX_W-1:0]; el_wdata = NO_EDGE;
    st_we = 1'b0; st_raddr = depth - 1'b1;
    add_a = cur_s; add_b = COUNT_BITS'(1);
    unique case (state)
      S_CLR: begin
        node_we = 1'b1; node_waddr = clr_cnt;
        node_wdata = '{seen: 1'b0, mval: 1'b0, visit: 1'b0, head: NO_EDGE, tail: '0};
      end
      S_RD_FROM: node_raddr = cur.from_node;
      S_UPD_FROM: begin
        node_we = 1'b1;
        node_wdata.seen = 1'b1;
        if (cur.has_edge && !e_full) begin
          if (nd.head == NO_EDGE) node_wdata.head = edges_stored;
          node_wdata.tail = edges_stored[EIDX_W-1:0];
          ed_we = 1'b1;
          el_we = 1'b1;
        end
      end
      S_LINK: begin
        el_we = 1'b1; el_waddr = link_addr; el_wdata = edges_stored - 1'b1;
      end
      S_RD_TO: node_raddr = cur.to_node;
      S_UPD_TO: begin
        node_we = 1'b1; node_waddr = cur.to_node; node_wdata.seen = 1'b1;
      end
      S_CK_RS: node_raddr = src_node;
      S_CK_RT: node_raddr = tgt_node;
      S_CK_EV: begin
        node_we = walk_go; node_waddr = src_node;
        node_wdata = src_w; node_wdata.visit = 1'b1;
      end
      S_W_EDGE: node_raddr = cur_n;
      S_W_DEST: node_raddr = ed_rdata;
      S_W_NODE: begin
        add_b = memo_rdata;
        if (!nd.mval && !nd.visit && !push_full) begin
          node_we = 1'b1; node_waddr = cur_d; node_wdata.visit = 1'b1;
          st_we = 1'b1;
        end
      end
      S_W_POP: begin
        node_we = 1'b1; node_waddr = cur_n;
        node_wdata.visit = 1'b0; node_wdata.mval = 1'b1;
        memo_we = 1'b1;
      end
      S_W_POP2: begin
        add_a = sw.sum; add_b = cur_s;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR; clr_cnt <= '0; edges_stored <= '0; full_flag <= 1'b0;
      src_node <= '0; tgt_node <= NODE_W'(1); result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        if (cfg_index == CFG_SOURCE) src_node <= cfg_data;
        if (cfg_index == CFG_TARGET) tgt_node <= cfg_data;
      end
      if (state == S_RES && (!result_valid || result_ready)) result_valid <= 1'b1;
      else if (result_ready) result_valid <= 1'b0;
      unique case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + 1'b1; edges_stored <= '0; full_flag <= 1'b0;
        end
        S_IDLE: if (item_valid) cur <= item;
        S_UPD_FROM: if (cur.has_edge) begin
          if (e_full) full_flag <= 1'b1;
          else begin
            edges_stored <= edges_stored + 1'b1;
            link_addr <= nd.tail;
          end
        end
        S_CK_RS: begin
          res_count <= '0; res_status <= ST_OK;
        end
        S_CK_RT: src_w <= nd;
        S_CK_EV: begin
          if (full_flag) res_status <= ST_FULL;
          else if (!src_w.seen) res_status <= ST_NO_SOURCE;
          else if (!nd.seen) res_status <= ST_NO_TARGET;
          else if (src_node == tgt_node) res_count <= COUNT_BITS'(1);
          cur_n <= src_node; cur_c <= src_w.head; cur_s <= '0; depth <= '0;
        end
        S_W_DEST: begin
          cur_c <= el_rdata; cur_d <= ed_rdata;
          if (ed_rdata == tgt_node) begin
            cur_s <= add_sum;
            if (add_ovf) res_status <= ST_OVERFLOW;
          end
        end
        S_W_NODE: begin
          if (nd.mval) begin
            cur_s <= add_sum;
            if (add_ovf) res_status <= ST_OVERFLOW;
          end else if (nd.visit || push_full) res_status <= ST_CYCLE;
          else begin
            depth <= depth + 1'b1; cur_n <= cur_d; cur_c <= nd.head; cur_s <= '0;
          end
        end
        S_W_POP: begin
          if (depth == '0) res_count <= cur_s;
          else depth <= depth - 1'b1;
        end
        S_W_POP2: begin
          cur_n <= sw.node; cur_c <= sw.cursor; cur_s <= add_sum;
          if (add_ovf) res_status <= ST_OVERFLOW;
        end
        S_RES: if (!result_valid || result_ready) begin
          clr_cnt <= '0;
          result.status <= res_status;
          result.path_count <= (res_status == ST_OK) ? res_count : '0;
        end
        default: ;
      endcase
    end
  end
endmodule

/* hdl/dag_path_counter_chk.sv */
// Port checker for the path counter, bound to the top level.
`timescale 1ns / 1ps
module dag_path_counter_chk (
  input logic          clk,
  input logic          rst,
  input logic          item_valid,
  input logic          item_ready,
  input dpc_pkg::in_t  item,
  input logic          result_valid,
  input logic          result_ready,
  input dpc_pkg::out_t result
);
  import dpc_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result word changed while stalled");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != ST_OK |-> result.path_count == '0)
    else $error("nonzero count with error status");

  a_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.status <= ST_FULL)
    else $error("status code out of range");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item.last_item |=> !item_ready)
    else $error("ready straight after last word");
endmodule

bind dag_path_counter dag_path_counter_chk u_chk (
  .clk, .rst, .item_valid, .item_ready, .item,
  .result_valid, .result_ready, .result);
